FILE: sv/response_frame_checker_macros.svh
// Assertion macros used by the reply frame checker top level.
`ifndef RESPONSE_FRAME_CHECKER_MACROS_SVH
`define RESPONSE_FRAME_CHECKER_MACROS_SVH

// Condition that must hold in the same cycle as its trigger.
`define RFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define RFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rfc_pkg.sv
// Shared types, codes and the CRC-16 byte update of the reply frame checker.
package rfc_pkg;

  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqByte  = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNak     = 2'd1;
  localparam logic [1:0] StatusCrcErr  = 2'd2;
  localparam logic [1:0] StatusTimeout = 2'd3;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [1:0] CfgCrcPoly     = 2'd0;
  localparam logic [1:0] CfgAckCode     = 2'd1;
  localparam logic [1:0] CfgEmptyMarker = 2'd2;
  localparam logic [1:0] CfgTimeout     = 2'd3;

  localparam logic [7:0]  FrameStart = 8'h52;
  localparam logic [7:0]  CmdGet     = 8'h47;
  localparam logic [7:0]  CmdCyclic  = 8'h43;
  localparam logic [15:0] TickMax    = 16'hFFFF;

  typedef struct packed {
    logic [15:0] crc_poly;
    logic [7:0]  ack_code;
    logic [7:0]  empty_marker;
    logic [15:0] timeout_ticks;
  } rfc_cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] sent_command;
    logic [7:0] sent_fifth_byte;
  } rfc_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [1:0] status;
  } rfc_result_t;

  typedef struct packed {
    logic        valid;
    logic        listening;
    rfc_result_t result;
  } rfc_step_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: sv/rfc_in_if.sv
// Input channel of the reply frame checker: one request item per transfer.
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [7:0] sent_command;
  logic [7:0] sent_fifth_byte;

  modport source (output valid, output req_type, output rx_byte, output sent_command,
                  output sent_fifth_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, input sent_command,
                input sent_fifth_byte, output ready);
endinterface

FILE: sv/rfc_out_if.sv
// Output channel of the reply frame checker: one result item per transfer.
interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [1:0] status;

  modport source (output valid, output result_kind, output data_byte, output status,
                  input ready);
  modport sink (input valid, input result_kind, input data_byte, input status,
                output ready);
endinterface

FILE: sv/rfc_parser.sv
// Frame state and per-item parse, CRC and timeout logic of the reply checker.
module rfc_parser import rfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_en_i,
  input  rfc_item_t item_i,
  input  rfc_cfg_t  cfg_i,
  output rfc_step_t step_o
);

  typedef enum logic [2:0] {
    PosHunt  = 3'd0,
    PosCmd   = 3'd1,
    PosAck   = 3'd2,
    PosCntLo = 3'd3,
    PosCntHi = 3'd4,
    PosData  = 3'd5,
    PosCrc   = 3'd6
  } pos_e;

  logic        listening_q, listening_d;
  pos_e        pos_q, pos_d;
  logic        expects_q, expects_d;
  logic [7:0]  exp_cmd_q, exp_cmd_d;
  logic [15:0] left_q, left_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [1:0]  crc_left_q, crc_left_d;
  logic [15:0] ticks_q, ticks_d;
  logic [15:0] crc_next;
  logic [15:0] ticks_inc;
  logic        res_v;
  rfc_result_t res;

  assign crc_next  = crc_feed(crc_q, item_i.rx_byte, cfg_i.crc_poly);
  assign ticks_inc = (ticks_q != TickMax) ? ticks_q + 16'd1 : ticks_q;

  always_comb begin
    listening_d = listening_q;
    pos_d       = pos_q;
    expects_d   = expects_q;
    exp_cmd_d   = exp_cmd_q;
    left_d      = left_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    crc_left_d  = crc_left_q;
    ticks_d     = ticks_q;
    res_v       = 1'b0;
    res         = '0;
    if (step_en_i) begin
      case (item_i.req_type)
        ReqStart: begin
          listening_d = 1'b1;
          pos_d       = PosHunt;
          exp_cmd_d   = item_i.sent_command;
          expects_d   = (item_i.sent_command == CmdGet) ||
                        (item_i.sent_command == CmdCyclic &&
                         item_i.sent_fifth_byte != cfg_i.empty_marker);
          left_d      = '0;
          crc_d       = '0;
          crc_lo_d    = '0;
          crc_left_d  = 2'd2;
          ticks_d     = '0;
        end
        ReqTick: begin
          if (listening_q) begin
            ticks_d = ticks_inc;
            if (ticks_inc >= cfg_i.timeout_ticks) begin
              listening_d = 1'b0;
              pos_d       = PosHunt;
              res_v       = 1'b1;
              res         = '{result_kind: KindStatus, data_byte: 8'h00,
                              status: StatusTimeout};
            end
          end
        end
        ReqByte: begin
          if (listening_q) begin
            unique case (pos_q)
              PosHunt: begin
                if (item_i.rx_byte == FrameStart) begin
                  crc_d = crc_next;
                  pos_d = PosCmd;
                end
              end
              PosCmd: begin
                if (item_i.rx_byte != exp_cmd_q) begin
                  crc_d = '0;
                  pos_d = PosHunt;
                end else begin
                  crc_d = crc_next;
                  pos_d = PosAck;
                end
              end
              PosAck: begin
                crc_d = crc_next;
                if (item_i.rx_byte != cfg_i.ack_code) begin
                  listening_d = 1'b0;
                  pos_d       = PosHunt;
                  res_v       = 1'b1;
                  res         = '{result_kind: KindStatus, data_byte: 8'h00,
                                  status: StatusNak};
                end else begin
                  pos_d = expects_q ? PosCntLo : PosCrc;
                end
              end
              PosCntLo: begin
                crc_d  = crc_next;
                left_d = {8'h00, item_i.rx_byte};
                pos_d  = PosCntHi;
              end
              PosCntHi: begin
                crc_d  = crc_next;
                left_d = {item_i.rx_byte, left_q[7:0]};
                pos_d  = PosData;
              end
              default: begin
                if (pos_q == PosData && left_q != 16'd0) begin
                  crc_d  = crc_next;
                  left_d = left_q - 16'd1;
                  res_v  = 1'b1;
                  res    = '{result_kind: KindData, data_byte: item_i.rx_byte,
                             status: StatusOk};
                end else begin
                  pos_d = PosCrc;
                  if (crc_left_q >= 2'd2) begin
                    crc_lo_d   = item_i.rx_byte;
                    crc_left_d = 2'd1;
                  end else begin
                    crc_left_d  = 2'd0;
                    listening_d = 1'b0;
                    pos_d       = PosHunt;
                    res_v       = 1'b1;
                    res.result_kind = KindStatus;
                    res.data_byte   = 8'h00;
                    res.status      = ({item_i.rx_byte, crc_lo_q} == crc_q) ?
                                      StatusOk : StatusCrcErr;
                  end
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listening_q <= 1'b0;
      pos_q       <= PosHunt;
      expects_q   <= 1'b0;
      exp_cmd_q   <= '0;
      left_q      <= '0;
      crc_q       <= '0;
      crc_lo_q    <= '0;
      crc_left_q  <= 2'd2;
      ticks_q     <= '0;
    end else begin
      listening_q <= listening_d;
      pos_q       <= pos_d;
      expects_q   <= expects_d;
      exp_cmd_q   <= exp_cmd_d;
      left_q      <= left_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
      crc_left_q  <= crc_left_d;
      ticks_q     <= ticks_d;
    end
  end

  assign step_o = '{valid: res_v, listening: listening_q, result: res};

endmodule

FILE: sv/response_frame_checker.sv
// Top level of the reply frame checker: channels, configuration and pipeline registers.
//
// Usage: each transfer on in_i carries one request item: a start (with the
// command and fifth byte of the request sent), a received byte, or a tick.
// Each item yields zero or one result on out_o: either a payload data byte
// or the end of the frame with a status (ok, no acknowledge, CRC mismatch,
// timeout). Configuration registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must do so only while no item is in flight, as the
// block itself does not enforce it. An accepted item is parsed combinationally
// from the input register into the result register that drives out_o.
// Throughput: one item per cycle while the receiver takes results, set by the
// combinational parse and the byte-wide CRC update between the input and the
// result register. Reset clears the frame state to idle, empties both
// registers and loads the default configuration. When the receiver stalls,
// the result register holds and the input register still takes one more
// item; after that in_i ready drops until the result is taken.
module response_frame_checker import rfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  rfc_in_if.sink      in_i,
  rfc_out_if.source   out_o
);

`include "response_frame_checker_macros.svh"

  rfc_cfg_t    cfg_q;
  logic        s1_v_q;
  rfc_item_t   s1_q;
  logic        out_v_q;
  rfc_result_t out_q;
  logic        adv;
  rfc_step_t   step;

  assign adv        = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_poly      <= 16'h1021;
      cfg_q.ack_code      <= 8'h06;
      cfg_q.empty_marker  <= 8'hFF;
      cfg_q.timeout_ticks <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCrcPoly:     cfg_q.crc_poly      <= cfg_data_i;
        CfgAckCode:     cfg_q.ack_code      <= cfg_data_i[7:0];
        CfgEmptyMarker: cfg_q.empty_marker  <= cfg_data_i[7:0];
        CfgTimeout:     cfg_q.timeout_ticks <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_v_q <= in_i.valid;
      end
      if (adv) begin
        out_v_q <= step.valid;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= '{req_type: in_i.req_type, rx_byte: in_i.rx_byte,
                sent_command: in_i.sent_command,
                sent_fifth_byte: in_i.sent_fifth_byte};
    end
    if (adv && step.valid) begin
      out_q <= step.result;
    end
  end

  rfc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (adv),
    .item_i    (s1_q),
    .cfg_i     (cfg_q),
    .step_o    (step)
  );

  assign out_o.valid       = out_v_q;
  assign out_o.result_kind = out_q.result_kind;
  assign out_o.data_byte   = out_q.data_byte;
  assign out_o.status      = out_q.status;

  `RFC_ASSERT_NOW(a_stall_only_when_full, !in_i.ready,
                  s1_v_q && out_v_q && !out_o.ready, "input stalled without a full pipeline")
  `RFC_ASSERT_NOW(a_data_has_ok_status, out_v_q && out_q.result_kind == KindData,
                  out_q.status == StatusOk, "data result with nonzero status")
  `RFC_ASSERT_NOW(a_status_has_no_data, out_v_q && out_q.result_kind == KindStatus,
                  out_q.data_byte == 8'h00, "status result with nonzero data")
  `RFC_ASSERT_NOW(a_idle_gives_nothing, adv && !step.listening,
                  !step.valid, "result produced while not listening")
  `RFC_ASSERT_NOW(a_timeout_on_tick, adv && step.valid && step.result.status == StatusTimeout
                  && step.result.result_kind == KindStatus,
                  s1_q.req_type == ReqTick, "timeout without a tick")
  `RFC_ASSERT_NEXT(a_result_registered, adv && step.valid,
                   out_v_q, "parsed result not registered")

endmodule

FILE: sim/rfc_reply_watch.sv
// Scoreboard for the reply frame checker: predicts and compares every output transfer.
`timescale 1ns / 1ps
module rfc_reply_watch import rfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  rfc_in_if           in_i,
  rfc_out_if          out_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    PosHunt, PosCmd, PosAck, PosCountLo, PosCountHi, PosData, PosCrc
  } parse_pos_e;

  logic [15:0] gen_poly;
  logic [7:0]  ack_value;
  logic [7:0]  no_data_marker;
  logic [15:0] tick_limit;

  logic        armed;
  parse_pos_e  parse_pos;
  logic        has_data;
  logic [7:0]  frame_cmd;
  logic [15:0] data_left;
  logic [15:0] run_crc;
  logic [7:0]  crc_first;
  logic [1:0]  crc_todo;
  logic [15:0] ticks_seen;

  rfc_result_t expected_results[$];
  rfc_item_t   seen_item;
  rfc_result_t seen_result;
  rfc_result_t due_result;
  rfc_result_t new_result;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
    end
    return c;
  endfunction

  function automatic bit end_frame(input logic [1:0] code, output rfc_result_t res);
    armed = 1'b0;
    parse_pos = PosHunt;
    res.result_kind = KindStatus;
    res.data_byte = 8'h00;
    res.status = code;
    return 1'b1;
  endfunction

  function automatic bit parse_item(input rfc_item_t it, output rfc_result_t res);
    logic [7:0] b;
    b = it.rx_byte;
    res = '0;
    if (it.req_type == ReqStart) begin
      armed = 1'b1;
      parse_pos = PosHunt;
      frame_cmd = it.sent_command;
      has_data = (it.sent_command == CmdGet) ||
                 (it.sent_command == CmdCyclic && it.sent_fifth_byte != no_data_marker);
      data_left = 16'h0000;
      run_crc = 16'h0000;
      crc_first = 8'h00;
      crc_todo = 2'd2;
      ticks_seen = 16'h0000;
      return 1'b0;
    end
    if (!armed) return 1'b0;
    if (it.req_type == ReqTick) begin
      if (ticks_seen != TickMax) ticks_seen++;
      if (ticks_seen >= tick_limit) return end_frame(StatusTimeout, res);
      return 1'b0;
    end
    if (it.req_type != ReqByte) return 1'b0;
    case (parse_pos)
      PosHunt: begin
        if (b == FrameStart) begin
          run_crc = crc_next(run_crc, b, gen_poly);
          parse_pos = PosCmd;
        end
      end
      PosCmd: begin
        if (b != frame_cmd) begin
          run_crc = 16'h0000;
          parse_pos = PosHunt;
        end else begin
          run_crc = crc_next(run_crc, b, gen_poly);
          parse_pos = PosAck;
        end
      end
      PosAck: begin
        run_crc = crc_next(run_crc, b, gen_poly);
        if (b != ack_value) return end_frame(StatusNak, res);
        parse_pos = has_data ? PosCountLo : PosCrc;
      end
      PosCountLo: begin
        run_crc = crc_next(run_crc, b, gen_poly);
        data_left = {8'h00, b};
        parse_pos = PosCountHi;
      end
      PosCountHi: begin
        run_crc = crc_next(run_crc, b, gen_poly);
        data_left[15:8] = b;
        parse_pos = PosData;
      end
      default: begin
        if (parse_pos == PosData && data_left != 16'h0000) begin
          run_crc = crc_next(run_crc, b, gen_poly);
          data_left--;
          res.result_kind = KindData;
          res.data_byte = b;
          res.status = StatusOk;
          return 1'b1;
        end
        parse_pos = PosCrc;
        if (crc_todo >= 2'd2) begin
          crc_first = b;
          crc_todo = 2'd1;
          return 1'b0;
        end
        crc_todo = 2'd0;
        return end_frame(({b, crc_first} == run_crc) ? StatusOk : StatusCrcErr, res);
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_poly = 16'h1021;
      ack_value = 8'h06;
      no_data_marker = 8'hFF;
      tick_limit = 16'd1000;
      armed = 1'b0;
      parse_pos = PosHunt;
      has_data = 1'b0;
      frame_cmd = 8'h00;
      data_left = 16'h0000;
      run_crc = 16'h0000;
      crc_first = 8'h00;
      crc_todo = 2'd2;
      ticks_seen = 16'h0000;
      expected_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        seen_result.result_kind = out_i.result_kind;
        seen_result.data_byte = out_i.data_byte;
        seen_result.status = out_i.status;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d data %02h status %0d",
                   $time, seen_result.result_kind, seen_result.data_byte, seen_result.status);
          fail_count_o++;
        end else begin
          due_result = expected_results.pop_front();
          if (seen_result.result_kind !== due_result.result_kind ||
              seen_result.data_byte !== due_result.data_byte ||
              seen_result.status !== due_result.status) begin
            $display("%0t: result mismatch, expected kind %0d data %02h status %0d, %s",
                     $time, due_result.result_kind, due_result.data_byte, due_result.status,
                     $sformatf("got kind %0d data %02h status %0d", seen_result.result_kind,
                               seen_result.data_byte, seen_result.status));
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCrcPoly:     gen_poly = cfg_data_i;
          CfgAckCode:     ack_value = cfg_data_i[7:0];
          CfgEmptyMarker: no_data_marker = cfg_data_i[7:0];
          default:        tick_limit = cfg_data_i;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        seen_item.req_type = in_i.req_type;
        seen_item.rx_byte = in_i.rx_byte;
        seen_item.sent_command = in_i.sent_command;
        seen_item.sent_fifth_byte = in_i.sent_fifth_byte;
        if (parse_item(seen_item, new_result)) begin
          expected_results.insert(expected_results.size(), new_result);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: sim/tb_response_frame_checker.sv
// Testbench top for the reply frame checker: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_response_frame_checker import rfc_pkg::*; ();

  localparam logic [1:0] ReqUnused = 2'd3;

  typedef enum int {FlawNone, FlawBadCmd, FlawNak, FlawBadCrc, FlawCut} frame_flaw_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  rfc_in_if  in_ch ();
  rfc_out_if out_ch ();

  response_frame_checker uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  rfc_reply_watch reply_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  logic [15:0] cur_poly = 16'h1021;
  logic [7:0]  cur_ack = 8'h06;
  logic [7:0]  cur_empty = 8'hFF;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  int          noise_max = 0;
  int          tick_pct = 0;
  int          stray_pct = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int          phase_base;
  int          sel;
  logic [7:0]  fcmd;
  logic [7:0]  ffifth;
  logic [15:0] fcount;
  frame_flaw_e fflaw;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(8, 64);
        end
        rx_mode_left--;
        case (rx_mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = ($urandom_range(0, 1) == 1);
          default: out_ch.ready = ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  function automatic rfc_item_t make_item(input logic [1:0] req, input logic [7:0] b);
    rfc_item_t it;
    it.req_type = req;
    it.rx_byte = b;
    it.sent_command = 8'($urandom_range(0, 255));
    it.sent_fifth_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic offer(input rfc_item_t it);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0 && !no_gaps) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid = 1'b1;
    in_ch.req_type = it.req_type;
    in_ch.rx_byte = it.rx_byte;
    in_ch.sent_command = it.sent_command;
    in_ch.sent_fifth_byte = it.sent_fifth_byte;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic arm(input logic [7:0] cmd, input logic [7:0] fifth);
    rfc_item_t it;
    it = make_item(ReqStart, 8'($urandom_range(0, 255)));
    it.sent_command = cmd;
    it.sent_fifth_byte = fifth;
    offer(it);
  endtask

  task automatic put_byte(input logic [7:0] b, inout logic [15:0] crc);
    if ($urandom_range(0, 99) < tick_pct) offer(make_item(ReqTick, 8'($urandom_range(0, 255))));
    if ($urandom_range(0, 99) < stray_pct) begin
      offer(make_item(ReqUnused, 8'($urandom_range(0, 255))));
    end
    offer(make_item(ReqByte, b));
    crc = reply_watch.crc_next(crc, b, cur_poly);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] fifth,
                            input logic [15:0] count, input frame_flaw_e flaw);
    logic [15:0] crc;
    logic [15:0] sum;
    logic [7:0]  b;
    arm(cmd, fifth);
    crc = 16'h0000;
    repeat ($urandom_range(0, noise_max)) begin
      b = 8'($urandom_range(0, 255));
      put_byte((b == FrameStart) ? ~b : b, crc);
    end
    if (flaw == FlawBadCmd) begin
      put_byte(FrameStart, crc);
      put_byte((cmd == FrameStart) ? ~cmd : FrameStart, crc);
    end
    crc = 16'h0000;
    put_byte(FrameStart, crc);
    put_byte(cmd, crc);
    if (flaw == FlawNak) begin
      put_byte(cur_ack ^ 8'($urandom_range(1, 255)), crc);
      return;
    end
    put_byte(cur_ack, crc);
    if (cmd == CmdGet || (cmd == CmdCyclic && fifth != cur_empty)) begin
      put_byte(count[7:0], crc);
      put_byte(count[15:8], crc);
      repeat (count) put_byte(8'($urandom_range(0, 255)), crc);
    end
    if (flaw == FlawCut) return;
    sum = crc;
    if (flaw == FlawBadCrc) sum ^= 16'($urandom_range(1, 65535));
    put_byte(sum[7:0], crc);
    put_byte(sum[15:8], crc);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = value;
    case (idx)
      CfgCrcPoly:     cur_poly = value;
      CfgAckCode:     cur_ack = value[7:0];
      CfgEmptyMarker: cur_empty = value[7:0];
      default:        ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = ReqStart;
    in_ch.rx_byte = 8'h00;
    in_ch.sent_command = 8'h00;
    in_ch.sent_fifth_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_idx = CfgCrcPoly;
    cfg_data = 16'h0000;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    offer(make_item(ReqByte, 8'hFF));
    offer(make_item(ReqTick, 8'h00));
    offer(make_item(ReqUnused, 8'h52));
    send_frame(CmdCyclic, 8'hFF, 16'd0, FlawBadCmd);
    send_frame(CmdGet, 8'h00, 16'd0, FlawNone);
    arm(CmdGet, 8'hFF);
    send_frame(CmdCyclic, 8'h00, 16'd2, FlawNak);
    wait_idle();

    noise_max = 2;
    stray_pct = 2;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CfgCrcPoly, 16'h1021);
          write_reg(CfgAckCode, 16'h0006);
          write_reg(CfgEmptyMarker, 16'h00FF);
          write_reg(CfgTimeout, 16'd1000);
          tick_pct = 0;
        end
        1: begin
          write_reg(CfgCrcPoly, 16'hFFFF);
          write_reg(CfgAckCode, 16'h0000);
          write_reg(CfgEmptyMarker, 16'h0000);
          write_reg(CfgTimeout, 16'hFFFF);
          tick_pct = 3;
        end
        2: begin
          write_reg(CfgCrcPoly, 16'h0000);
          write_reg(CfgAckCode, 16'h00FF);
          write_reg(CfgEmptyMarker, 16'($urandom_range(0, 255)));
          write_reg(CfgTimeout, 16'd1);
          tick_pct = 4;
        end
        3: begin
          write_reg(CfgCrcPoly, 16'h8005);
          write_reg(CfgAckCode, 16'($urandom_range(0, 255)));
          write_reg(CfgEmptyMarker, 16'($urandom_range(0, 255)));
          write_reg(CfgTimeout, 16'd0);
          tick_pct = 3;
        end
        4: begin
          write_reg(CfgCrcPoly, 16'($urandom_range(0, 65535)));
          write_reg(CfgAckCode, 16'($urandom_range(0, 255)));
          write_reg(CfgEmptyMarker, 16'($urandom_range(0, 255)));
          write_reg(CfgTimeout, 16'($urandom_range(8, 40)));
          tick_pct = 10;
        end
        default: begin
          write_reg(CfgCrcPoly, 16'($urandom_range(0, 65535)));
          write_reg(CfgAckCode, 16'($urandom_range(0, 255)));
          write_reg(CfgEmptyMarker, 16'($urandom_range(0, 255)));
          write_reg(CfgTimeout, 16'($urandom_range(1, 65535)));
          tick_pct = 8;
        end
      endcase
      phase_base = items_sent;
      if (phase == 0) begin
        no_gaps = 1'b1;
        hold_left = 150;
        send_frame(CmdGet, 8'h00, 16'd40, FlawNone);
        no_gaps = 1'b0;
      end
      if (phase == 1) send_frame(CmdGet, 8'h00, 16'h0104, FlawNone);
      while (items_sent - phase_base < 50) begin
        sel = $urandom_range(0, 9);
        fcmd = (sel < 4) ? CmdGet : (sel < 8) ? CmdCyclic : 8'($urandom_range(0, 255));
        ffifth = ($urandom_range(0, 1) == 1) ? cur_empty : 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 19);
        fcount = (sel == 0) ? 16'd0 :
                 (sel < 17) ? 16'($urandom_range(1, 6)) : 16'($urandom_range(7, 24));
        sel = $urandom_range(0, 19);
        fflaw = (sel < 13) ? FlawNone : (sel < 15) ? FlawBadCmd :
                (sel < 17) ? FlawNak : (sel < 19) ? FlawBadCrc : FlawCut;
        send_frame(fcmd, ffifth, fcount, fflaw);
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/rfc_pkg.sv
sv/rfc_in_if.sv
sv/rfc_out_if.sv
sv/rfc_parser.sv
sv/response_frame_checker.sv
sim/rfc_reply_watch.sv
sim/tb_response_frame_checker.sv
